### sv/tci_pkg.sv
`default_nettype none
package tci_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int SAMPLE_BITS = 32;

    localparam int FRAC_W = FRAC_BITS + 1;
    // a convex blend of samples scaled by one Q factor per axis
    localparam int EX_W   = SAMPLE_BITS + FRAC_BITS;
    localparam int EY_W   = SAMPLE_BITS + 2 * FRAC_BITS;
    localparam int SUM_W  = SAMPLE_BITS + 3 * FRAC_BITS;
    localparam int RND_SH = 3 * FRAC_BITS;

    localparam logic [FRAC_W-1:0] ONE_Q = FRAC_W'(1) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) << (RND_SH - 1);

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic        [FRAC_W-1:0]      frac_x;
        logic        [FRAC_W-1:0]      frac_y;
        logic        [FRAC_W-1:0]      frac_z;
        logic signed [SAMPLE_BITS-1:0] corner_000;
        logic signed [SAMPLE_BITS-1:0] corner_100;
        logic signed [SAMPLE_BITS-1:0] corner_010;
        logic signed [SAMPLE_BITS-1:0] corner_110;
        logic signed [SAMPLE_BITS-1:0] corner_001;
        logic signed [SAMPLE_BITS-1:0] corner_101;
        logic signed [SAMPLE_BITS-1:0] corner_011;
        logic signed [SAMPLE_BITS-1:0] corner_111;
        logic signed [SAMPLE_BITS-1:0] accumulate_in;
    } t_req;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] interp_value;
        logic                          saturated;
    } t_res;

    function automatic logic [FRAC_W-1:0] clamp_frac(input logic [FRAC_W-1:0] f);
        clamp_frac = (f > ONE_Q) ? ONE_Q : f;
    endfunction

endpackage
`default_nettype wire

### sv/tci_xlane.sv
`default_nettype none
module tci_xlane
    import tci_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic signed [SAMPLE_BITS-1:0] i_c0,
    input  wire logic signed [SAMPLE_BITS-1:0] i_c1,
    input  wire logic        [FRAC_W-1:0]      i_f,
    output logic signed      [EX_W-1:0]        o_ex
);

    localparam int PW = SAMPLE_BITS + FRAC_BITS + 3;

    logic signed [SAMPLE_BITS:0] diff;
    logic signed [PW-1:0]        prod;
    logic signed [PW-1:0]        sum;
    logic signed [EX_W-1:0]      r_ex;

    // c0*(1-f) + c1*f == (c0 << F) + (c1-c0)*f
    assign diff = (SAMPLE_BITS+1)'(i_c1) - (SAMPLE_BITS+1)'(i_c0);
    assign prod = PW'(diff) * $signed(PW'(i_f));
    assign sum  = (PW'(i_c0) <<< FRAC_BITS) + prod;

    always_ff @(posedge i_clk) begin
        r_ex <= sum[EX_W-1:0];
    end

    assign o_ex = r_ex;

endmodule
`default_nettype wire

### sv/tci_merge.sv
`default_nettype none
module tci_merge
    import tci_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic signed [EX_W-1:0]        i_ex [4],
    input  wire logic        [FRAC_W-1:0]      i_fy,
    input  wire logic        [FRAC_W-1:0]      i_fz,
    input  wire logic signed [SAMPLE_BITS-1:0] i_acc,
    output logic                               o_strobe,
    output t_res                               o_res
);

    localparam int PY_W = EY_W + 3;
    localparam int PZ_W = SUM_W + 3;

    // y stage: two lanes
    logic signed [EX_W:0]   dy   [2];
    logic signed [PY_W-1:0] sy   [2];
    logic signed [EY_W-1:0] r_ey [2];
    logic [FRAC_W-1:0]      r_fz2;
    logic signed [SAMPLE_BITS-1:0] r_acc2, r_acc3;
    logic r_v2, r_v3, r_strobe;

    // z stage
    logic signed [EY_W:0]   dz;
    logic signed [PZ_W-1:0] sz;
    logic signed [SUM_W-1:0] r_s;

    // round and saturate
    logic signed [SUM_W-1:0]       rnd;
    logic signed [SAMPLE_BITS-1:0] blend;
    logic signed [SAMPLE_BITS:0]   total;
    logic                          sat;
    t_res                          n_res, r_res;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            dy[i] = (EX_W+1)'(i_ex[2*i+1]) - (EX_W+1)'(i_ex[2*i]);
            sy[i] = (PY_W'(i_ex[2*i]) <<< FRAC_BITS) + PY_W'(dy[i]) * $signed(PY_W'(i_fy));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 2; i++) begin
            r_ey[i] <= sy[i][EY_W-1:0];
        end
        r_fz2  <= i_fz;
        r_acc2 <= i_acc;
    end

    assign dz = (EY_W+1)'(r_ey[1]) - (EY_W+1)'(r_ey[0]);
    assign sz = (PZ_W'(r_ey[0]) <<< FRAC_BITS) + PZ_W'(dz) * $signed(PZ_W'(r_fz2));

    always_ff @(posedge i_clk) begin
        r_s    <= sz[SUM_W-1:0];
        r_acc3 <= r_acc2;
    end

    // round half up, drop the 3F fraction bits, add the running value
    always_comb begin
        rnd   = r_s + HALF_LSB;
        blend = rnd[SUM_W-1:RND_SH];
        total = (SAMPLE_BITS+1)'(blend) + (SAMPLE_BITS+1)'(r_acc3);
        sat   = total[SAMPLE_BITS] != total[SAMPLE_BITS-1];
        n_res.saturated = sat;
        if (sat) begin
            n_res.interp_value = total[SAMPLE_BITS] ? SAMPLE_MIN : SAMPLE_MAX;
        end else begin
            n_res.interp_value = total[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_v2     <= i_valid;
            r_v3     <= r_v2;
            r_strobe <= r_v3;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule
`default_nettype wire

### sv/trilinear_corner_interpolator.sv
`default_nettype none
// channel   ports                    handshake
// -------   ----------------------   ------------------------------------
// request   i_req (t_req)            taken when start is high, busy is low
// result    o_res (t_res)            valid for one cycle while o_strobe high
//
// Fully pipelined: one request per cycle. A request passes the x lane, y lane,
// z merge and round/saturate registers in that order; o_strobe and the result
// are registered together in the last of them.
// busy never rises; results cannot be held off and none is ever dropped.
// Synchronous active-low reset clears the valid pipeline only.
module trilinear_corner_interpolator
    import tci_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_strobe,
    output t_res      o_res
);

    logic [FRAC_W-1:0] fx, fy, fz;
    logic [FRAC_W-1:0] r_fy1, r_fz1;
    logic signed [SAMPLE_BITS-1:0] r_acc1;
    logic signed [SAMPLE_BITS-1:0] c [8];
    logic signed [EX_W-1:0] ex [4];
    logic r_v1;

    assign busy = 1'b0;

    assign fx = clamp_frac(i_req.frac_x);
    assign fy = clamp_frac(i_req.frac_y);
    assign fz = clamp_frac(i_req.frac_z);

    // corner index bit 0 is x, bit 1 is y, bit 2 is z
    assign c[0] = i_req.corner_000;
    assign c[1] = i_req.corner_100;
    assign c[2] = i_req.corner_010;
    assign c[3] = i_req.corner_110;
    assign c[4] = i_req.corner_001;
    assign c[5] = i_req.corner_101;
    assign c[6] = i_req.corner_011;
    assign c[7] = i_req.corner_111;

    for (genvar g = 0; g < 4; g++) begin : g_xlane
        tci_xlane u_xlane (
            .i_clk (i_clk),
            .i_c0  (c[2*g]),
            .i_c1  (c[2*g+1]),
            .i_f   (fx),
            .o_ex  (ex[g])
        );
    end

    always_ff @(posedge i_clk) begin
        r_fy1  <= fy;
        r_fz1  <= fz;
        r_acc1 <= i_req.accumulate_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start & ~busy;
        end
    end

    tci_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v1),
        .i_ex     (ex),
        .i_fy     (r_fy1),
        .i_fz     (r_fz1),
        .i_acc    (r_acc1),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule
`default_nettype wire
